// ===== hw/rtl/graph_neighbor_sampler_core_defines.svh =====
// assertion macros for the neighbor sampler
`ifndef GRAPH_NEIGHBOR_SAMPLER_CORE_DEFINES_SVH
`define GRAPH_NEIGHBOR_SAMPLER_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define GNS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define GNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/gns_pkg.sv =====
// package: constants, types and state codes of the neighbor sampler
`default_nettype none
package gns_pkg;
  localparam int NODE_COUNT = 65536;
  localparam int EDGE_COUNT = 1048576;
  localparam int MAX_FANOUT = 64;
  localparam int NODE_W = $clog2(NODE_COUNT + 1);
  localparam int OFFS_W = $clog2(EDGE_COUNT + 1);
  localparam int EIDX_W = $clog2(EDGE_COUNT);
  localparam int NADDR_W = $clog2(NODE_COUNT);
  localparam int ID_W = 16;
  localparam int FAN_W = 7;
  localparam int CNT_W = $clog2(MAX_FANOUT + 1);

  localparam logic [1:0] FUNC_OFFSET = 2'd0;
  localparam logic [1:0] FUNC_NEIGHBOR = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  localparam logic CFG_FANOUT = 1'b0;
  localparam logic CFG_SEED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFF_RD,
    ST_OFF_WAIT,
    ST_LEN,
    ST_RAND,
    ST_MUL,
    ST_RD_A,
    ST_RD_B,
    ST_SWAP,
    ST_EMIT
  } state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic off_rd;     // read both offsets of the seed
    logic calc_len;   // form degree and pick count
    logic rand_step;  // step the generator
    logic mul;        // scale the draw to the range
    logic rd_a;       // read the chosen entry
    logic rd_b;       // read the tail entry
    logic swap;       // write the tail entry into the chosen slot
    logic emit;       // emit one edge and finish the swap
  } dp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic empty;   // degree zero or no pick
    logic full;    // degree at most fanout: no draw
    logic last;    // current pick is the final one
  } dp_stat_t;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/gns_ctrl.sv =====
// controller state machine of the neighbor sampler
`default_nettype none
module gns_ctrl import gns_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     go,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd,
  output logic          busy
);
  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (go) begin
          cmd.off_rd = 1'b1;
          state_next = ST_OFF_RD;
        end
      end
      ST_OFF_RD: state_next = ST_OFF_WAIT;
      ST_OFF_WAIT: begin
        cmd.calc_len = 1'b1;
        state_next = ST_LEN;
      end
      ST_LEN: begin
        if (stat.empty) state_next = ST_IDLE;
        else if (stat.full) state_next = ST_RD_A;
        else state_next = ST_RAND;
      end
      ST_RAND: begin
        cmd.rand_step = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_RD_A;
      end
      ST_RD_A: begin
        cmd.rd_a = 1'b1;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_b = 1'b1;
        if (stat.full) state_next = ST_EMIT;
        else state_next = ST_SWAP;
      end
      ST_SWAP: begin
        cmd.swap = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.last) state_next = ST_IDLE;
        else if (stat.full) state_next = ST_RD_A;
        else state_next = ST_RAND;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/gns_datapath.sv =====
// datapath: tables, random generator, pick counter and result register
`default_nettype none
module gns_datapath import gns_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [1:0]        func,
  input  wire logic [NODE_W-1:0] node,
  input  wire logic [OFFS_W-1:0] offset_value,
  input  wire logic [EIDX_W-1:0] edge_index,
  input  wire logic [ID_W-1:0]   neighbor_id,
  input  wire logic              last_seed,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output logic                   go,
  output logic                   result_valid,
  output logic [ID_W-1:0]        source_node,
  output logic [ID_W-1:0]        sampled_neighbor,
  output logic                   last_edge,
  output logic                   batch_end
);
  logic [OFFS_W-1:0] offset_mem [NODE_COUNT+1];
  logic [ID_W-1:0]   nbr_mem [EDGE_COUNT];

  logic [FAN_W-1:0]  fanout;
  logic [31:0]       rnd;
  logic [NADDR_W-1:0] seed;
  logic              seed_last;
  logic [OFFS_W-1:0] off_lo, off_hi, off_base;
  logic [OFFS_W-1:0] range;
  logic [CNT_W-1:0]  count, pick;
  logic              full, empty;
  logic [EIDX_W-1:0] addr_a, addr_b;
  logic [ID_W-1:0]   data_a, data_b;
  logic [63:0]       prod;

  logic              is_sample;
  logic [OFFS_W-1:0] end_cl, len_raw;
  logic [FAN_W-1:0]  fo_sat;

  // a sample of an in-range seed starts the controller
  assign is_sample = (func == FUNC_SAMPLE) && (node < NODE_W'(NODE_COUNT));
  assign go = accept && is_sample;

  // configuration registers and generator
  always_ff @(posedge clk) begin
    if (rst) begin
      fanout <= FAN_W'(10);
      rnd <= 32'd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FANOUT) fanout <= cfg_data[FAN_W-1:0];
      else rnd <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
    end else if (cmd.rand_step) begin
      rnd <= xorshift(rnd);
    end
  end

  // offset table: one write port, two registered reads
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_OFFSET && node <= NODE_W'(NODE_COUNT))
      offset_mem[node] <= offset_value;
    if (cmd.off_rd) begin
      off_lo <= offset_mem[node];
      off_hi <= offset_mem[node + NODE_W'(1)];
    end
  end

  // degree and pick count
  assign end_cl = (off_hi > OFFS_W'(EDGE_COUNT)) ? OFFS_W'(EDGE_COUNT) : off_hi;
  assign len_raw = end_cl - off_lo;
  assign fo_sat = (fanout > FAN_W'(MAX_FANOUT)) ? FAN_W'(MAX_FANOUT) : fanout;

  always_ff @(posedge clk) begin
    if (go) begin
      seed <= node[NADDR_W-1:0];
      seed_last <= last_seed;
    end
    if (cmd.calc_len) begin
      off_base <= off_lo;
      pick <= '0;
      if (end_cl <= off_lo || fo_sat == '0) begin
        empty <= 1'b1;
        full <= 1'b0;
        count <= '0;
      end else begin
        empty <= 1'b0;
        range <= len_raw;
        full <= (len_raw <= OFFS_W'(fo_sat));
        count <= (len_raw <= OFFS_W'(fo_sat)) ? CNT_W'(len_raw) : CNT_W'(fo_sat);
      end
    end
    if (cmd.mul) prod <= 64'(rnd) * 64'(range);
    if (cmd.emit) begin
      pick <= pick + CNT_W'(1);
      range <= range - OFFS_W'(1);
    end
  end

  // entry addresses: stored order when the degree fits, else draw and tail
  assign addr_a = full ? EIDX_W'(off_base + OFFS_W'(pick))
                       : EIDX_W'(off_base + OFFS_W'(prod[63:32]));
  assign addr_b = EIDX_W'(off_base + range - OFFS_W'(1));

  // neighbor table: single port, one access a cycle, swap as two reads then two writes
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_NEIGHBOR) nbr_mem[edge_index] <= neighbor_id;
    else if (cmd.rd_a) data_a <= nbr_mem[addr_a];
    else if (cmd.rd_b) data_b <= nbr_mem[addr_b];
    else if (cmd.swap) nbr_mem[addr_a] <= data_b;
    else if (cmd.emit && !full) nbr_mem[addr_b] <= data_a;
  end

  assign stat.empty = empty;
  assign stat.full = full;
  assign stat.last = (pick + CNT_W'(1) == count);

  // result register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cmd.emit;
    if (cmd.emit) begin
      source_node <= ID_W'(seed);
      sampled_neighbor <= data_a;
      last_edge <= stat.last;
      batch_end <= stat.last && seed_last;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/graph_neighbor_sampler_core.sv =====
// top level of the graph neighbor sampler
// Usage: items enter on start while busy is low. func 0 writes an offset entry,
// func 1 a neighbor entry, func 2 samples a seed. A sample reads both offsets,
// then for each pick: a generator step, a scale multiply, two table reads and
// two swap writes; when the degree fits in fanout only the two reads remain.
// busy stays high until the sample ends, so no new item enters meanwhile; the
// single neighbor table port sets the rate.
// Each edge appears for one cycle with result_valid; the receiver cannot
// stall. last_edge marks the final edge of a seed, batch_end that of a
// last_seed item. Configuration: cfg_valid/cfg_ready with cfg_index
// 0 fanout, 1 random_seed; cfg_ready is high while idle.
// Reset sets fanout 10 and the generator to 1; tables stay undefined until
// written and need no clearing pass.
`default_nettype none
`include "graph_neighbor_sampler_core_defines.svh"
module graph_neighbor_sampler_core import gns_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        func,
  input  wire logic [NODE_W-1:0] node,
  input  wire logic [OFFS_W-1:0] offset_value,
  input  wire logic [EIDX_W-1:0] edge_index,
  input  wire logic [ID_W-1:0]   neighbor_id,
  input  wire logic              last_seed,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic                   result_valid,
  output logic [ID_W-1:0]        source_node,
  output logic [ID_W-1:0]        sampled_neighbor,
  output logic                   last_edge,
  output logic                   batch_end
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     go, accept, ctrl_busy;

  assign accept = start && !busy;
  assign busy = ctrl_busy;
  assign cfg_ready = !ctrl_busy;

  gns_ctrl u_ctrl (
    .clk, .rst, .go, .stat, .cmd, .busy(ctrl_busy)
  );

  gns_datapath u_dp (
    .clk, .rst, .accept, .func, .node, .offset_value, .edge_index,
    .neighbor_id, .last_seed,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index[0]), .cfg_data,
    .cmd, .stat, .go, .result_valid, .source_node, .sampled_neighbor,
    .last_edge, .batch_end
  );

  // checks
  `GNS_ASSERT_IMP(a_batch_has_last, result_valid && batch_end, last_edge)
  `GNS_ASSERT_NEXT(a_emit_gives_result, cmd.emit, result_valid)
  `GNS_ASSERT_IMP(a_no_cmd_idle, !ctrl_busy && !go, cmd == '0)
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// testbench of the graph neighbor sampler: directed and random items against a local predictor
`default_nettype none
module tb;
  import gns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ID_W-1:0] src;
    logic [ID_W-1:0] nbr;
    logic            last_edge;
    logic            batch_end;
  } edge_t;

  localparam int DRAIN_CYCLES = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] func = FUNC_OFFSET;
  logic [NODE_W-1:0] node = '0;
  logic [OFFS_W-1:0] offset_value = '0;
  logic [EIDX_W-1:0] edge_index = '0;
  logic [ID_W-1:0] neighbor_id = '0;
  logic last_seed = 1'b0;
  logic cfg_valid = 1'b0;
  logic [0:0] cfg_index = CFG_FANOUT;
  logic [31:0] cfg_data = '0;
  logic busy, cfg_ready, result_valid, last_edge, batch_end;
  logic [ID_W-1:0] source_node, sampled_neighbor;

  graph_neighbor_sampler_core dut (
    .clk, .rst, .start, .busy, .func, .node, .offset_value, .edge_index,
    .neighbor_id, .last_seed, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .result_valid, .source_node, .sampled_neighbor, .last_edge, .batch_end
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: sparse copies of both tables plus registers
  logic [OFFS_W-1:0] off_mem [int];
  logic [ID_W-1:0] nbr_mem [int];
  logic [31:0] rng_state = 32'd1;
  logic [FAN_W-1:0] fanout_reg = 7'd10;
  edge_t edges_due [$];
  int errors = 0;
  int gap_pct = 0;

  function automatic logic [31:0] rng_next(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // expected edges of one accepted item
  task automatic predict_edges(input logic [1:0] f, input logic [NODE_W-1:0] n,
                               input logic [OFFS_W-1:0] ov, input logic [EIDX_W-1:0] ei,
                               input logic [ID_W-1:0] ni, input logic ls);
    longint base, stop, deg, fo, cnt, rng, k, a, b;
    logic [63:0] prod;
    logic [ID_W-1:0] pick;
    edge_t e;
    if (f == FUNC_OFFSET) begin
      if (n <= NODE_COUNT) off_mem[int'(n)] = ov;
    end else if (f == FUNC_NEIGHBOR) begin
      if (ei < EDGE_COUNT) nbr_mem[int'(ei)] = ni;
    end else if (f == FUNC_SAMPLE && n < NODE_COUNT) begin
      base = off_mem.exists(int'(n)) ? off_mem[int'(n)] : 0;
      stop = off_mem.exists(int'(n) + 1) ? off_mem[int'(n) + 1] : 0;
      if (stop > EDGE_COUNT) stop = EDGE_COUNT;
      fo = (fanout_reg > MAX_FANOUT) ? MAX_FANOUT : fanout_reg;
      if (stop > base && fo != 0) begin
        deg = stop - base;
        cnt = (deg <= fo) ? deg : fo;
        for (longint j = 0; j < cnt; j++) begin
          if (deg <= fo) begin
            pick = nbr_mem[int'(base + j)];
          end else begin
            rng = deg - j;
            rng_state = rng_next(rng_state);
            prod = {32'd0, rng_state} * 64'(rng);
            k = longint'(prod >> 32);
            a = base + k;
            b = base + rng - 1;
            pick = nbr_mem[int'(a)];
            nbr_mem[int'(a)] = nbr_mem[int'(b)];
            nbr_mem[int'(b)] = pick;
          end
          e.src = n[ID_W-1:0];
          e.nbr = pick;
          e.last_edge = (j + 1 == cnt);
          e.batch_end = (j + 1 == cnt) && ls;
          edges_due.push_back(e);
        end
      end
    end
  endtask

  // one item transfer, sometimes with a random gap before it
  task automatic send_item(input logic [1:0] f, input logic [NODE_W-1:0] n,
                           input logic [OFFS_W-1:0] ov, input logic [EIDX_W-1:0] ei,
                           input logic [ID_W-1:0] ni, input logic ls);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    node <= n;
    offset_value <= ov;
    edge_index <= ei;
    neighbor_id <= ni;
    last_seed <= ls;
    do @(posedge clk); while (busy);
    predict_edges(f, n, ov, ei, ni, ls);
  endtask

  // helpers that fill unused fields with random bits
  task automatic put_offset(input logic [NODE_W-1:0] n, input logic [OFFS_W-1:0] ov);
    send_item(FUNC_OFFSET, n, ov, EIDX_W'($urandom), ID_W'($urandom), 1'($urandom));
  endtask

  task automatic put_neighbor(input logic [EIDX_W-1:0] ei, input logic [ID_W-1:0] ni);
    send_item(FUNC_NEIGHBOR, NODE_W'($urandom), OFFS_W'($urandom), ei, ni, 1'($urandom));
  endtask

  task automatic sample(input logic [NODE_W-1:0] n, input logic ls);
    send_item(FUNC_SAMPLE, n, OFFS_W'($urandom), EIDX_W'($urandom), ID_W'($urandom), ls);
  endtask

  // let every expected edge arrive and the block settle
  task automatic drain();
    start <= 1'b0;
    while (edges_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write transfer while idle
  task automatic write_cfg(input logic [0:0] idx, input logic [31:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FANOUT) begin
      fanout_reg = data[FAN_W-1:0];
    end else begin
      rng_state = (data == 0) ? 32'd1 : data;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    edge_t e;
    if (!rst && result_valid) begin
      if (edges_due.size() == 0) begin
        if (errors < 10) $display("unexpected edge %h -> %h", source_node, sampled_neighbor);
        errors++;
      end else begin
        e = edges_due.pop_front();
        if (e.src !== source_node || e.nbr !== sampled_neighbor ||
            e.last_edge !== last_edge || e.batch_end !== batch_end) begin
          if (errors < 10)
            $display("edge mismatch: exp %h %h %b %b got %h %h %b %b", e.src, e.nbr,
                     e.last_edge, e.batch_end, source_node, sampled_neighbor,
                     last_edge, batch_end);
          errors++;
        end
      end
    end
  end

  // table writes at the index extremes, clamping, reversed and ignored items
  task automatic test_table_edges();
    put_offset(17'd0, 21'd0);
    put_offset(17'd1, 21'd4);
    put_neighbor(20'd0, 16'h0000);
    put_neighbor(20'd1, 16'hFFFF);
    put_neighbor(20'd2, 16'h5A5A);
    put_neighbor(20'd3, 16'hA5A5);
    sample(17'd0, 1'b1);
    // end offset above the table is clamped
    put_offset(17'd65535, 21'(EDGE_COUNT - 2));
    put_offset(17'd65536, 21'h1FFFFF);
    put_neighbor(20'hFFFFE, 16'h1234);
    put_neighbor(20'hFFFFF, 16'hFEDC);
    sample(17'd65535, 1'b1);
    // reversed offsets give nothing
    put_offset(17'd2, 21'd0);
    sample(17'd1, 1'b1);
    // ignored: seed and offset index out of range, unused func
    sample(17'd65536, 1'b1);
    sample(17'h1FFFF, 1'b0);
    put_offset(17'h1FFFF, 21'd7);
    send_item(2'd3, 17'h1FFFF, 21'h1FFFFF, 20'hFFFFF, 16'hFFFF, 1'b1);
    sample(17'd0, 1'b0);
  endtask

  // fanout extremes and seed values, including zero and saturation
  task automatic test_config_extremes();
    logic [31:0] fans [4] = '{32'd1, 32'd64, 32'd0, 32'd127};
    write_cfg(CFG_SEED, 32'd0);
    foreach (fans[i]) begin
      write_cfg(CFG_FANOUT, fans[i]);
      sample(17'd0, 1'b1);
      sample(17'd65535, 1'b0);
    end
    write_cfg(CFG_FANOUT, 32'd2);
    write_cfg(CFG_SEED, 32'hFFFFFFFF);
    sample(17'd0, 1'b1);
    sample(17'd0, 1'b1);
  endtask

  // random graphs built and sampled, plus noise
  task automatic test_random(input int items);
    int sent, n, base, deg, kind;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(2'd3, NODE_W'($urandom), OFFS_W'($urandom), EIDX_W'($urandom),
                       ID_W'($urandom), 1'($urandom));
          1: sample(NODE_W'($urandom_range(NODE_COUNT, 17'h1FFFF)), 1'($urandom));
          default: put_offset(NODE_W'($urandom_range(NODE_COUNT + 1, 17'h1FFFF)),
                              OFFS_W'($urandom));
        endcase
        sent++;
      end else begin
        n = $urandom_range(0, NODE_COUNT - 2);
        base = $urandom_range(0, EDGE_COUNT - 64);
        case ($urandom_range(0, 9))
          0: deg = 0;
          8: deg = $urandom_range(17, 40);
          9: deg = -int'($urandom_range(1, 5));
          default: deg = $urandom_range(1, 16);
        endcase
        if (base + deg < 0) deg = 0;
        put_offset(NODE_W'(n), OFFS_W'(base));
        put_offset(NODE_W'(n + 1), OFFS_W'(base + deg));
        sent += 2;
        for (int i = 0; i < deg; i++) begin
          put_neighbor(EIDX_W'(base + i), ID_W'($urandom));
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          sample(NODE_W'(n), 1'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_pct = 19;
    test_table_edges();
    test_config_extremes();
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 19 : (ph == 1) ? 51 : 0;
      write_cfg(CFG_FANOUT, $urandom_range(1, 14));
      write_cfg(CFG_SEED, $urandom);
      test_random(110);
    end
    drain();
    if (errors == 0 && edges_due.size() == 0) begin
      $display("PASS graph_neighbor_sampler_core");
    end else begin
      $display("FAIL graph_neighbor_sampler_core");
    end
    $finish;
  end

  // run limit
  initial begin
    #8ms;
    $display("FAIL graph_neighbor_sampler_core");
    $finish;
  end
endmodule
`default_nettype wire
